### hw/rtl/dle_sfr_pkg.sv
// Shared types, constants and CRC helper for the DLE/STX frame receiver.
package dle_sfr_pkg;

  localparam logic [7:0]  DLE_BYTE = 8'h90;
  localparam logic [7:0]  STX_BYTE = 8'h02;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  ZERO_BYTE = 8'h00;

  typedef enum logic [3:0] {
    PH_HUNT_DLE = 4'd0,
    PH_HUNT_STX = 4'd1,
    PH_OPCODE   = 4'd2,
    PH_LEN      = 4'd3,
    PH_DATA     = 4'd4,
    PH_CRC_LO   = 4'd5,
    PH_CRC_HI   = 4'd6,
    PH_ESC_OP   = 4'd7,
    PH_ESC_LEN  = 4'd8,
    PH_ESC_DATA = 4'd9,
    PH_ESC_CLO  = 4'd10,
    PH_ESC_CHI  = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_FRAME_OK = 2'd1,
    KIND_CRC_BAD  = 2'd2,
    KIND_ESC_ERR  = 2'd3
  } kind_t;

  // Shift one byte into the CRC, MSB first.
  function automatic logic [15:0] crc_feed_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        carry;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      carry = c[15];
      c = {c[14:0], b[i]};
      if (carry) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/dle_sfr_byte_if.sv
// Input channel carrying one stuffed serial byte per item.
interface dle_sfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/dle_sfr_result_if.sv
// Result channel carrying one payload byte or frame verdict per item.
interface dle_sfr_result_if;
  logic                 valid;
  logic                 ready;
  dle_sfr_pkg::kind_t   kind;
  logic [7:0]           frame_opcode;
  logic [7:0]           word_count;
  logic [8:0]           byte_index;
  logic [7:0]           payload_byte;
  logic [15:0]          received_crc;
  logic [15:0]          computed_crc;
  logic [31:0]          comm_error;

  modport source (output valid, output kind, output frame_opcode, output word_count,
                  output byte_index, output payload_byte, output received_crc,
                  output computed_crc, output comm_error, input ready);
  modport sink   (input valid, input kind, input frame_opcode, input word_count,
                  input byte_index, input payload_byte, input received_crc,
                  input computed_crc, input comm_error, output ready);
endinterface

### hw/rtl/dle_stuffed_frame_receiver_unit.sv
// DLE/STX byte-stuffed frame receiver with CRC-CCITT check.
//
// in_ch takes one received serial byte per item, still stuffed. The block
// hunts for DLE STX, then parses opcode, length in words, payload and a
// little-endian CRC, undoing DLE doubling on the way. out_ch gives one item
// per payload byte, one at each frame end (CRC ok or mismatch, with the
// first four payload bytes) and one for an invalid byte after DLE; bytes
// that only move the parser give no item.
// An accepted byte lands in an input register; its result is then registered
// in the output register, from which out_ch takes it. One byte per cycle is
// sustained while out_ch does not stall; the CRC update folds a whole
// two-byte word into the accumulator at once.
// Reset (rst_n low, synchronous) empties both registers, clears the frame
// state and puts the parser back to hunting for DLE.
// When out_ch stalls, the pending result and the input register's byte hold;
// in_ch.ready stays high only while the input register is empty or can move.
module dle_stuffed_frame_receiver_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  dle_sfr_byte_if.sink            in_ch,
  dle_sfr_result_if.source        out_ch
);

  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                advance;

  dle_sfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]          opcode_r, opcode_nxt;
  logic [7:0]          length_r, length_nxt;
  logic [8:0]          byte_cnt_r, byte_cnt_nxt;
  logic [7:0]          pend_r, pend_nxt;
  logic [15:0]         crc_acc_r, crc_acc_nxt;
  logic [15:0]         crc_rx_r, crc_rx_nxt;
  logic [31:0]         err_word_r, err_word_nxt;

  logic                out_vld_r;
  dle_sfr_pkg::kind_t  out_kind_r, res_kind;
  logic [7:0]          out_op_r, out_len_r;
  logic [8:0]          out_idx_r, res_idx;
  logic [7:0]          out_pb_r, res_pb;
  logic [15:0]         out_rcrc_r, res_rcrc;
  logic [15:0]         out_ccrc_r, res_ccrc;
  logic [31:0]         out_err_r, res_err;
  logic                res_vld;

  logic                is_dle, is_stx, esc, esc_lit;
  logic [7:0]          d;
  logic [8:0]          cnt_inc;
  logic                data_end;
  logic [15:0]         crc_final;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  assign is_dle   = (in_byte_r == dle_sfr_pkg::DLE_BYTE);
  assign is_stx   = (in_byte_r == dle_sfr_pkg::STX_BYTE);
  assign esc      = (phase_r == dle_sfr_pkg::PH_ESC_OP)   || (phase_r == dle_sfr_pkg::PH_ESC_LEN) ||
                    (phase_r == dle_sfr_pkg::PH_ESC_DATA) || (phase_r == dle_sfr_pkg::PH_ESC_CLO) ||
                    (phase_r == dle_sfr_pkg::PH_ESC_CHI);
  assign esc_lit  = esc && is_dle;
  assign d        = esc ? dle_sfr_pkg::DLE_BYTE : in_byte_r;
  assign cnt_inc  = byte_cnt_r + 9'd1;
  assign data_end = (cnt_inc == {length_r, 1'b0});
  assign crc_final = dle_sfr_pkg::crc_feed_byte(
                       dle_sfr_pkg::crc_feed_byte(crc_acc_r, dle_sfr_pkg::ZERO_BYTE),
                       dle_sfr_pkg::ZERO_BYTE);

  // Next parse phase.
  always_comb begin
    phase_nxt = dle_sfr_pkg::PH_HUNT_DLE;
    unique case (phase_r)
      dle_sfr_pkg::PH_HUNT_DLE: begin
        phase_nxt = is_dle ? dle_sfr_pkg::PH_HUNT_STX : dle_sfr_pkg::PH_HUNT_DLE;
      end
      dle_sfr_pkg::PH_HUNT_STX: begin
        phase_nxt = is_stx ? dle_sfr_pkg::PH_OPCODE : dle_sfr_pkg::PH_HUNT_DLE;
      end
      dle_sfr_pkg::PH_OPCODE: begin
        phase_nxt = is_dle ? dle_sfr_pkg::PH_ESC_OP : dle_sfr_pkg::PH_LEN;
      end
      dle_sfr_pkg::PH_LEN: begin
        if (is_dle) phase_nxt = dle_sfr_pkg::PH_ESC_LEN;
        else if (in_byte_r == dle_sfr_pkg::ZERO_BYTE) phase_nxt = dle_sfr_pkg::PH_CRC_LO;
        else phase_nxt = dle_sfr_pkg::PH_DATA;
      end
      dle_sfr_pkg::PH_DATA: begin
        if (is_dle) phase_nxt = dle_sfr_pkg::PH_ESC_DATA;
        else phase_nxt = data_end ? dle_sfr_pkg::PH_CRC_LO : dle_sfr_pkg::PH_DATA;
      end
      dle_sfr_pkg::PH_CRC_LO: begin
        phase_nxt = is_dle ? dle_sfr_pkg::PH_ESC_CLO : dle_sfr_pkg::PH_CRC_HI;
      end
      dle_sfr_pkg::PH_CRC_HI: begin
        phase_nxt = is_dle ? dle_sfr_pkg::PH_ESC_CHI : dle_sfr_pkg::PH_HUNT_DLE;
      end
      dle_sfr_pkg::PH_ESC_OP, dle_sfr_pkg::PH_ESC_LEN, dle_sfr_pkg::PH_ESC_DATA,
      dle_sfr_pkg::PH_ESC_CLO, dle_sfr_pkg::PH_ESC_CHI: begin
        if (is_stx) phase_nxt = dle_sfr_pkg::PH_OPCODE;
        else if (!is_dle) phase_nxt = dle_sfr_pkg::PH_HUNT_DLE;
        else begin
          unique case (phase_r)
            dle_sfr_pkg::PH_ESC_OP:   phase_nxt = dle_sfr_pkg::PH_LEN;
            dle_sfr_pkg::PH_ESC_LEN:  phase_nxt = dle_sfr_pkg::PH_DATA;
            dle_sfr_pkg::PH_ESC_DATA: begin
              phase_nxt = data_end ? dle_sfr_pkg::PH_CRC_LO : dle_sfr_pkg::PH_DATA;
            end
            dle_sfr_pkg::PH_ESC_CLO:  phase_nxt = dle_sfr_pkg::PH_CRC_HI;
            default:                  phase_nxt = dle_sfr_pkg::PH_HUNT_DLE;
          endcase
        end
      end
      default: phase_nxt = dle_sfr_pkg::PH_HUNT_DLE;
    endcase
  end

  // Frame state updates and result fields.
  always_comb begin
    opcode_nxt   = opcode_r;
    length_nxt   = length_r;
    byte_cnt_nxt = byte_cnt_r;
    pend_nxt     = pend_r;
    crc_acc_nxt  = crc_acc_r;
    crc_rx_nxt   = crc_rx_r;
    err_word_nxt = err_word_r;
    res_vld      = 1'b0;
    res_kind     = dle_sfr_pkg::KIND_PAYLOAD;
    res_idx      = '0;
    res_pb       = '0;
    res_rcrc     = '0;
    res_ccrc     = '0;
    res_err      = '0;

    if (((phase_r == dle_sfr_pkg::PH_HUNT_STX) || esc) && is_stx) begin
      opcode_nxt   = '0;
      length_nxt   = '0;
      byte_cnt_nxt = '0;
      pend_nxt     = '0;
      crc_acc_nxt  = '0;
      crc_rx_nxt   = '0;
      err_word_nxt = '0;
    end else if (esc && !is_dle) begin
      res_vld  = 1'b1;
      res_kind = dle_sfr_pkg::KIND_ESC_ERR;
    end else if (((phase_r == dle_sfr_pkg::PH_OPCODE) && !is_dle) ||
                 ((phase_r == dle_sfr_pkg::PH_ESC_OP) && esc_lit)) begin
      opcode_nxt = d;
    end else if (((phase_r == dle_sfr_pkg::PH_LEN) && !is_dle) ||
                 ((phase_r == dle_sfr_pkg::PH_ESC_LEN) && esc_lit)) begin
      length_nxt  = d;
      crc_acc_nxt = dle_sfr_pkg::crc_feed_byte(dle_sfr_pkg::crc_feed_byte(crc_acc_r, d),
                                               opcode_r);
    end else if (((phase_r == dle_sfr_pkg::PH_DATA) && !is_dle) ||
                 ((phase_r == dle_sfr_pkg::PH_ESC_DATA) && esc_lit)) begin
      if (byte_cnt_r[8:2] == '0) begin
        unique case (byte_cnt_r[1:0])
          2'd0:    err_word_nxt = err_word_r | {24'd0, d};
          2'd1:    err_word_nxt = err_word_r | {16'd0, d, 8'd0};
          2'd2:    err_word_nxt = err_word_r | {8'd0, d, 16'd0};
          default: err_word_nxt = err_word_r | {d, 24'd0};
        endcase
      end
      if (byte_cnt_r[0]) begin
        crc_acc_nxt = dle_sfr_pkg::crc_feed_byte(dle_sfr_pkg::crc_feed_byte(crc_acc_r, d),
                                                 pend_r);
      end else begin
        pend_nxt = d;
      end
      byte_cnt_nxt = cnt_inc;
      res_vld      = 1'b1;
      res_kind     = dle_sfr_pkg::KIND_PAYLOAD;
      res_idx      = byte_cnt_r;
      res_pb       = d;
    end else if (((phase_r == dle_sfr_pkg::PH_CRC_LO) && !is_dle) ||
                 ((phase_r == dle_sfr_pkg::PH_ESC_CLO) && esc_lit)) begin
      crc_rx_nxt = {8'd0, d};
    end else if (((phase_r == dle_sfr_pkg::PH_CRC_HI) && !is_dle) ||
                 ((phase_r == dle_sfr_pkg::PH_ESC_CHI) && esc_lit)) begin
      crc_rx_nxt  = {d, crc_rx_r[7:0]};
      crc_acc_nxt = crc_final;
      res_vld     = 1'b1;
      res_kind    = (crc_final == {d, crc_rx_r[7:0]}) ? dle_sfr_pkg::KIND_FRAME_OK
                                                      : dle_sfr_pkg::KIND_CRC_BAD;
      res_rcrc    = {d, crc_rx_r[7:0]};
      res_ccrc    = crc_final;
      res_err     = err_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      phase_r    <= dle_sfr_pkg::PH_HUNT_DLE;
      opcode_r   <= '0;
      length_r   <= '0;
      byte_cnt_r <= '0;
      pend_r     <= '0;
      crc_acc_r  <= '0;
      crc_rx_r   <= '0;
      err_word_r <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r  <= res_vld;
        phase_r    <= phase_nxt;
        opcode_r   <= opcode_nxt;
        length_r   <= length_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        pend_r     <= pend_nxt;
        crc_acc_r  <= crc_acc_nxt;
        crc_rx_r   <= crc_rx_nxt;
        err_word_r <= err_word_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (advance && res_vld) begin
      out_kind_r <= res_kind;
      out_op_r   <= opcode_r;
      out_len_r  <= length_r;
      out_idx_r  <= res_idx;
      out_pb_r   <= res_pb;
      out_rcrc_r <= res_rcrc;
      out_ccrc_r <= res_ccrc;
      out_err_r  <= res_err;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.frame_opcode = out_op_r;
  assign out_ch.word_count   = out_len_r;
  assign out_ch.byte_index   = out_idx_r;
  assign out_ch.payload_byte = out_pb_r;
  assign out_ch.received_crc = out_rcrc_r;
  assign out_ch.computed_crc = out_ccrc_r;
  assign out_ch.comm_error   = out_err_r;

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == dle_sfr_pkg::PH_DATA) || (phase_r == dle_sfr_pkg::PH_ESC_DATA))
      |-> (byte_cnt_r < {length_r, 1'b0}))
    else $error("byte counter past frame length in data phase");

  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (phase_r == dle_sfr_pkg::PH_CRC_HI) && !is_dle) |=> out_vld_r)
    else $error("frame end did not produce a result");

  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r == dle_sfr_pkg::KIND_FRAME_OK)) |-> (out_rcrc_r == out_ccrc_r))
    else $error("frame ok reported with differing CRCs");

  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ((phase_r == dle_sfr_pkg::PH_HUNT_DLE) || (phase_r == dle_sfr_pkg::PH_HUNT_STX)))
      |=> !out_vld_r)
    else $error("result produced while hunting for frame start");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the DLE/STX stuffed frame receiver: random frames, noise, checks.
module tb_top;

  typedef struct packed {
    dle_sfr_pkg::kind_t kind;
    logic [7:0]         opcode;
    logic [7:0]         words;
    logic [8:0]         index;
    logic [7:0]         data;
    logic [15:0]        rx_crc;
    logic [15:0]        calc_crc;
    logic [31:0]        err_word;
  } frame_result_t;

  typedef struct packed {
    logic       drain;
    logic [7:0] value;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dle_sfr_byte_if   in_if ();
  dle_sfr_result_if out_if ();

  dle_stuffed_frame_receiver_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  stim_t         pending[$];
  frame_result_t results_due[$];
  logic [7:0]    frame_body[$];
  logic [7:0]    frame_raw[$];
  bit            drain_next = 1'b0;
  int            bytes_taken = 0;
  int            err_count = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;
  frame_result_t got_result;
  frame_result_t want_result;

  dle_sfr_pkg::phase_t rx_phase = dle_sfr_pkg::PH_HUNT_DLE;
  logic [7:0]  op_q = 8'h00;
  logic [7:0]  len_q = 8'h00;
  logic [8:0]  cnt_q = 9'h000;
  logic [7:0]  low_q = 8'h00;
  logic [15:0] crc_q = 16'h0000;
  logic [15:0] rx_crc_q = 16'h0000;
  logic [31:0] err_q = 32'h0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        top;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      top = r[15];
      r = {r[14:0], b[k]} ^ (dle_sfr_pkg::CRC_POLY & {16{top}});
    end
    return r;
  endfunction

  function automatic bit side_idles();
    if (bytes_taken >= 200 && bytes_taken < 360) return 1'b0;
    return $urandom_range(0, 99) < 33;
  endfunction

  function automatic logic [7:0] any_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return dle_sfr_pkg::DLE_BYTE;
    if (r < 25) return dle_sfr_pkg::STX_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic clear_frame();
    op_q = 8'h00;
    len_q = 8'h00;
    cnt_q = 9'h000;
    low_q = 8'h00;
    crc_q = 16'h0000;
    rx_crc_q = 16'h0000;
    err_q = 32'h0;
  endtask

  task automatic take_len(input logic [7:0] b);
    len_q = b;
    crc_q = crc_step(crc_step(crc_q, len_q), op_q);
    rx_phase = (len_q == 8'h00) ? dle_sfr_pkg::PH_CRC_LO : dle_sfr_pkg::PH_DATA;
  endtask

  task automatic take_data(input logic [7:0] b);
    frame_result_t r;
    logic [8:0]    idx;
    idx = cnt_q;
    if (idx < 9'd4) err_q[8 * idx[1:0] +: 8] = b;
    if (idx[0]) crc_q = crc_step(crc_step(crc_q, b), low_q);
    else low_q = b;
    cnt_q = idx + 9'd1;
    rx_phase = (cnt_q == {len_q, 1'b0}) ? dle_sfr_pkg::PH_CRC_LO : dle_sfr_pkg::PH_DATA;
    r = '0;
    r.kind = dle_sfr_pkg::KIND_PAYLOAD;
    r.opcode = op_q;
    r.words = len_q;
    r.index = idx;
    r.data = b;
    results_due.push_back(r);
  endtask

  task automatic finish_frame(input logic [7:0] hi);
    frame_result_t r;
    logic [15:0]   c;
    rx_crc_q[15:8] = hi;
    c = crc_step(crc_step(crc_q, dle_sfr_pkg::ZERO_BYTE), dle_sfr_pkg::ZERO_BYTE);
    crc_q = c;
    rx_phase = dle_sfr_pkg::PH_HUNT_DLE;
    r = '0;
    r.kind = (c == rx_crc_q) ? dle_sfr_pkg::KIND_FRAME_OK : dle_sfr_pkg::KIND_CRC_BAD;
    r.opcode = op_q;
    r.words = len_q;
    r.rx_crc = rx_crc_q;
    r.calc_crc = c;
    r.err_word = err_q;
    results_due.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    unique case (rx_phase)
      dle_sfr_pkg::PH_HUNT_DLE: begin
        if (b == dle_sfr_pkg::DLE_BYTE) rx_phase = dle_sfr_pkg::PH_HUNT_STX;
      end
      dle_sfr_pkg::PH_HUNT_STX: begin
        if (b == dle_sfr_pkg::STX_BYTE) begin
          clear_frame();
          rx_phase = dle_sfr_pkg::PH_OPCODE;
        end else begin
          rx_phase = dle_sfr_pkg::PH_HUNT_DLE;
        end
      end
      dle_sfr_pkg::PH_OPCODE: begin
        if (b == dle_sfr_pkg::DLE_BYTE) rx_phase = dle_sfr_pkg::PH_ESC_OP;
        else begin
          op_q = b;
          rx_phase = dle_sfr_pkg::PH_LEN;
        end
      end
      dle_sfr_pkg::PH_LEN: begin
        if (b == dle_sfr_pkg::DLE_BYTE) rx_phase = dle_sfr_pkg::PH_ESC_LEN;
        else take_len(b);
      end
      dle_sfr_pkg::PH_DATA: begin
        if (b == dle_sfr_pkg::DLE_BYTE) rx_phase = dle_sfr_pkg::PH_ESC_DATA;
        else take_data(b);
      end
      dle_sfr_pkg::PH_CRC_LO: begin
        if (b == dle_sfr_pkg::DLE_BYTE) rx_phase = dle_sfr_pkg::PH_ESC_CLO;
        else begin
          rx_crc_q = {8'h00, b};
          rx_phase = dle_sfr_pkg::PH_CRC_HI;
        end
      end
      dle_sfr_pkg::PH_CRC_HI: begin
        if (b == dle_sfr_pkg::DLE_BYTE) rx_phase = dle_sfr_pkg::PH_ESC_CHI;
        else finish_frame(b);
      end
      dle_sfr_pkg::PH_ESC_OP, dle_sfr_pkg::PH_ESC_LEN, dle_sfr_pkg::PH_ESC_DATA,
      dle_sfr_pkg::PH_ESC_CLO, dle_sfr_pkg::PH_ESC_CHI: begin
        if (b == dle_sfr_pkg::STX_BYTE) begin
          clear_frame();
          rx_phase = dle_sfr_pkg::PH_OPCODE;
        end else if (b != dle_sfr_pkg::DLE_BYTE) begin
          r = '0;
          r.kind = dle_sfr_pkg::KIND_ESC_ERR;
          r.opcode = op_q;
          r.words = len_q;
          results_due.push_back(r);
          rx_phase = dle_sfr_pkg::PH_HUNT_DLE;
        end else begin
          unique case (rx_phase)
            dle_sfr_pkg::PH_ESC_OP: begin
              op_q = dle_sfr_pkg::DLE_BYTE;
              rx_phase = dle_sfr_pkg::PH_LEN;
            end
            dle_sfr_pkg::PH_ESC_LEN:  take_len(dle_sfr_pkg::DLE_BYTE);
            dle_sfr_pkg::PH_ESC_DATA: take_data(dle_sfr_pkg::DLE_BYTE);
            dle_sfr_pkg::PH_ESC_CLO: begin
              rx_crc_q = {8'h00, dle_sfr_pkg::DLE_BYTE};
              rx_phase = dle_sfr_pkg::PH_CRC_HI;
            end
            default:                  finish_frame(dle_sfr_pkg::DLE_BYTE);
          endcase
        end
      end
      default: rx_phase = dle_sfr_pkg::PH_HUNT_DLE;
    endcase
  endtask

  task automatic log_error(input string what, input frame_result_t want,
                           input frame_result_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%s: expected kind %0d op %02h words %0d idx %0d byte %02h",
               what, want.kind, want.opcode, want.words, want.index, want.data);
      $display("    expected rcrc %04h ccrc %04h err %08h",
               want.rx_crc, want.calc_crc, want.err_word);
      $display("    actual   kind %0d op %02h words %0d idx %0d byte %02h",
               got.kind, got.opcode, got.words, got.index, got.data);
      $display("    actual   rcrc %04h ccrc %04h err %08h",
               got.rx_crc, got.calc_crc, got.err_word);
    end
  endtask

  task automatic offer(input logic [7:0] b);
    stim_t s;
    s.drain = drain_next;
    s.value = b;
    pending.push_back(s);
    drain_next = 1'b0;
  endtask

  task automatic stuff(input logic [7:0] b);
    frame_raw.push_back(b);
    if (b == dle_sfr_pkg::DLE_BYTE) frame_raw.push_back(dle_sfr_pkg::DLE_BYTE);
  endtask

  task automatic fill_body(input int words);
    frame_body.delete();
    repeat (2 * words) frame_body.push_back(any_byte());
  endtask

  task automatic add_frame(input logic [7:0] opc, input bit crc_ok, input int keep);
    logic [7:0]  lenb;
    logic [15:0] c;
    lenb = 8'(frame_body.size() / 2);
    c = crc_step(crc_step(16'h0000, lenb), opc);
    for (int i = 0; i + 1 < frame_body.size(); i += 2)
      c = crc_step(crc_step(c, frame_body[i + 1]), frame_body[i]);
    c = crc_step(crc_step(c, dle_sfr_pkg::ZERO_BYTE), dle_sfr_pkg::ZERO_BYTE);
    if (!crc_ok) c = c ^ (16'h0001 << $urandom_range(0, 15));
    frame_raw.delete();
    frame_raw.push_back(dle_sfr_pkg::DLE_BYTE);
    frame_raw.push_back(dle_sfr_pkg::STX_BYTE);
    stuff(opc);
    stuff(lenb);
    foreach (frame_body[i]) stuff(frame_body[i]);
    stuff(c[7:0]);
    stuff(c[15:8]);
    if (keep < 0 || keep > frame_raw.size()) keep = frame_raw.size();
    for (int i = 0; i < keep; i++) offer(frame_raw[i]);
  endtask

  initial begin
    int         pick;
    int         dir_len;
    logic [7:0] bad;
    bit         big_done;
    big_done = 1'b0;

    // zero length, escaped opcode, wrong crc
    frame_body.delete();
    add_frame(dle_sfr_pkg::DLE_BYTE, 1'b0, -1);
    // hunt: second DLE drops back to hunting
    offer(dle_sfr_pkg::DLE_BYTE);
    offer(dle_sfr_pkg::DLE_BYTE);
    offer(dle_sfr_pkg::STX_BYTE);
    // invalid byte after DLE
    offer(dle_sfr_pkg::DLE_BYTE);
    offer(dle_sfr_pkg::STX_BYTE);
    offer(dle_sfr_pkg::DLE_BYTE);
    offer(8'h41);
    // restart inside a frame, then stuffed payload with extremes
    offer(dle_sfr_pkg::DLE_BYTE);
    offer(dle_sfr_pkg::STX_BYTE);
    offer(8'hA5);
    frame_body = '{dle_sfr_pkg::DLE_BYTE, dle_sfr_pkg::STX_BYTE, 8'hFF, 8'h00};
    add_frame(8'hFF, 1'b1, -1);
    dir_len = pending.size();

    drain_next = 1'b1;
    while (pending.size() < dir_len + 670) begin
      pick = $urandom_range(0, 99);
      if (!big_done && pending.size() > dir_len + 60) begin
        big_done = 1'b1;
        drain_next = 1'b1;
        fill_body(255);
        add_frame(any_byte(), 1'b1, -1);
      end else if (pick < 62) begin
        fill_body(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6));
        add_frame(any_byte(), $urandom_range(0, 4) != 0, -1);
      end else if (pick < 74) begin
        // cut short, unless the frame is no longer than the kept bytes; the next frame start restarts it
        fill_body(($urandom_range(0, 3) == 0) ? int'(any_byte()) : $urandom_range(0, 6));
        add_frame(any_byte(), 1'b1, $urandom_range(3, 14));
      end else if (pick < 86) begin
        fill_body($urandom_range(0, 6));
        add_frame(any_byte(), 1'b1, $urandom_range(2, 14));
        bad = 8'($urandom_range(0, 255));
        if (bad == dle_sfr_pkg::DLE_BYTE || bad == dle_sfr_pkg::STX_BYTE) bad = 8'h41;
        offer(dle_sfr_pkg::DLE_BYTE);
        offer(bad);
      end else begin
        repeat ($urandom_range(1, 6)) offer(any_byte());
      end
    end

    while (pending.size() != 0 || in_if.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.rx_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.rx_byte);
        bytes_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending.size() != 0 && !(pending[0].drain && results_due.size() != 0) &&
            !side_idles()) begin
          in_if.valid <= 1'b1;
          in_if.rx_byte <= pending[0].value;
          void'(pending.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= 450) begin
      hold_done <= 1'b1;
      hold_left <= 150;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_result.kind = out_if.kind;
        got_result.opcode = out_if.frame_opcode;
        got_result.words = out_if.word_count;
        got_result.index = out_if.byte_index;
        got_result.data = out_if.payload_byte;
        got_result.rx_crc = out_if.received_crc;
        got_result.calc_crc = out_if.computed_crc;
        got_result.err_word = out_if.comm_error;
        if (results_due.size() == 0) begin
          log_error("unexpected result", got_result, got_result);
        end else begin
          want_result = results_due.pop_front();
          if (got_result !== want_result) log_error("result mismatch", want_result, got_result);
        end
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !side_idles();
      end
    end
  end

endmodule

### files.f
hw/rtl/dle_sfr_pkg.sv
hw/rtl/dle_sfr_byte_if.sv
hw/rtl/dle_sfr_result_if.sv
hw/rtl/dle_stuffed_frame_receiver_unit.sv
tb/sv/tb_top.sv
